@@ hw/rtl/text_console_writer_assert.svh @@
// ============================================================================
// Text console writer assertion macros
// Concurrent check wrappers clocked on clk and held off during rst.
// ============================================================================
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define TCW_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define TCW_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define TCW_ASSERT_CLK(lbl, prop, msg)
`define TCW_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

@@ hw/rtl/tcw_pkg.sv @@
// ============================================================================
// Text console writer package
// Field widths, character codes, controller states and the command and
// status bundles shared by the controller and the datapath.
// ============================================================================
package tcw_pkg;

  localparam int DEF_COLS      = 80;
  localparam int DEF_ROWS      = 25;
  localparam int DEF_TAB_WIDTH = 4;

  localparam int FUNC_W  = 1;
  localparam int CHAR_W  = 8;
  localparam int ROW_W   = 5;
  localparam int COL_W   = 7;
  localparam int LIN_W   = 11;
  localparam int COLOR_W = 8;

  localparam logic [FUNC_W-1:0]  FUNC_READ   = 1'b1;

  localparam logic [CHAR_W-1:0]  CH_BLANK    = 8'h00;
  localparam logic [CHAR_W-1:0]  CH_TAB      = 8'h09;
  localparam logic [CHAR_W-1:0]  CH_LF       = 8'h0A;
  localparam logic [CHAR_W-1:0]  CH_CR       = 8'h0D;
  localparam logic [CHAR_W-1:0]  CH_SPACE    = 8'h20;
  localparam logic [COLOR_W-1:0] RESET_COLOR = 8'h07;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_STORE,
    ST_COPY,
    ST_DRAIN,
    ST_BOTTOM,
    ST_RD_OUT
  } tcw_state_t;

  typedef struct packed {
    logic load;
    logic wipe;
    logic scroll_start;
    logic copy;
    logic drain;
    logic bottom;
    logic store;
    logic out_load;
  } tcw_ctl_t;

  typedef struct packed {
    logic item_read;
    logic scroll_req;
    logic tab_zero;
    logic ptr_last;
    logic out_free;
  } tcw_stat_t;

endpackage

@@ hw/rtl/tcw_cmd_if.sv @@
// ============================================================================
// Text console writer command channel
// Valid/ready channel carrying one write or read transaction.
// ============================================================================
interface tcw_cmd_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [CHAR_W-1:0] char_code;
  logic [ROW_W-1:0]  read_row;
  logic [COL_W-1:0]  read_col;

  modport source (output valid, func, char_code, read_row, read_col, input ready);
  modport sink (input valid, func, char_code, read_row, read_col, output ready);
endinterface

@@ hw/rtl/tcw_rsp_if.sv @@
// ============================================================================
// Text console writer response channel
// Valid/ready channel carrying the cursor and the addressed cell.
// ============================================================================
interface tcw_rsp_if import tcw_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ROW_W-1:0]   cursor_row;
  logic [COL_W-1:0]   cursor_col;
  logic [LIN_W-1:0]   cursor_linear;
  logic [CHAR_W-1:0]  cell_char;
  logic [COLOR_W-1:0] cell_color;

  modport source (output valid, cursor_row, cursor_col, cursor_linear, cell_char,
                  cell_color, input ready);
  modport sink (input valid, cursor_row, cursor_col, cursor_linear, cell_char,
                cell_color, output ready);
endinterface

@@ hw/rtl/tcw_ctrl.sv @@
// ============================================================================
// Text console writer controller
// Sequences the screen clear, character stores, scroll copy and responses.
// ============================================================================
module tcw_ctrl import tcw_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  tcw_stat_t st,
  output tcw_ctl_t  ctl
);

  tcw_state_t state;
  tcw_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        ctl.wipe = 1'b1;
        if (st.ptr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load   = 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        priority if (st.item_read) begin
          state_next = ST_RD_OUT;
        end else if (st.scroll_req) begin
          ctl.scroll_start = 1'b1;
          state_next       = ST_COPY;
        end else if (!st.tab_zero) begin
          state_next = ST_STORE;
        end else if (st.out_free) begin
          ctl.out_load = 1'b1;
          state_next   = ST_IDLE;
        end else begin
          state_next = ST_RUN;
        end
      end
      ST_STORE: begin
        ctl.store  = 1'b1;
        state_next = ST_RUN;
      end
      ST_COPY: begin
        ctl.copy = 1'b1;
        if (st.ptr_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        ctl.drain  = 1'b1;
        state_next = ST_BOTTOM;
      end
      ST_BOTTOM: begin
        ctl.bottom = 1'b1;
        if (st.ptr_last) state_next = ST_RUN;
      end
      ST_RD_OUT: begin
        if (st.out_free) begin
          ctl.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

@@ hw/rtl/tcw_datapath.sv @@
// ============================================================================
// Text console writer datapath
// Screen store, cursor and tab counters, sweep pointer and response register.
// ============================================================================
module tcw_datapath import tcw_pkg::*; #(
  parameter int COLS      = DEF_COLS,
  parameter int ROWS      = DEF_ROWS,
  parameter int TAB_WIDTH = DEF_TAB_WIDTH
) (
  input  logic               clk,
  input  logic               rst,
  input  tcw_ctl_t           ctl,
  output tcw_stat_t          st,
  input  logic [FUNC_W-1:0]  in_func,
  input  logic [CHAR_W-1:0]  in_char,
  input  logic [ROW_W-1:0]   in_row,
  input  logic [COL_W-1:0]   in_col,
  input  logic               cfg_we,
  input  logic [COLOR_W-1:0] cfg_wdata,
  tcw_rsp_if.source          rsp
);

  localparam int CELLS = ROWS * COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLS);
  localparam int TW    = $clog2(TAB_WIDTH + 1);

  localparam logic [AW-1:0] LAST_BASE = AW'((ROWS - 1) * COLS);
  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0] ROW_STEP  = AW'(COLS);
  localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
  localparam logic [CW-1:0] LAST_COL  = CW'(COLS - 1);
  localparam logic [TW-1:0] TAB_N     = TW'(TAB_WIDTH);
  localparam logic [TW-1:0] TAB_LAST  = TW'(TAB_WIDTH - 1);

  logic [CHAR_W-1:0]  chars  [CELLS];
  logic [COLOR_W-1:0] colors [CELLS];

  logic [COLOR_W-1:0] default_color;
  logic [RW-1:0]      row;
  logic [CW-1:0]      col;
  logic [AW-1:0]      lin;
  logic [TW-1:0]      phase;
  logic [TW-1:0]      tab_left;
  logic [CHAR_W-1:0]  tab_char;
  logic               scroll_req;
  logic [AW-1:0]      ptr;
  logic               cp_pend;
  logic [AW-1:0]      cp_addr;
  logic               item_read;
  logic               item_ok;
  logic [AW-1:0]      item_addr;
  logic [CHAR_W-1:0]  rd_char;
  logic [COLOR_W-1:0] rd_color;
  logic               out_valid;

  logic               wr_en;
  logic               wr_color_en;
  logic [AW-1:0]      wr_addr;
  logic [CHAR_W-1:0]  wr_char;
  logic [COLOR_W-1:0] wr_color;
  logic [AW-1:0]      rd_addr;

  // Screen store
  always_comb begin
    wr_en       = 1'b0;
    wr_color_en = 1'b0;
    wr_addr     = ptr;
    wr_char     = CH_BLANK;
    wr_color    = RESET_COLOR;
    priority if (ctl.wipe) begin
      wr_en       = 1'b1;
      wr_color_en = 1'b1;
    end else if (ctl.bottom) begin
      wr_en       = 1'b1;
      wr_color_en = 1'b1;
      wr_color    = default_color;
    end else if (cp_pend) begin
      wr_en       = 1'b1;
      wr_color_en = 1'b1;
      wr_addr     = cp_addr;
      wr_char     = rd_char;
      wr_color    = rd_color;
    end else if (ctl.store) begin
      wr_en   = 1'b1;
      wr_addr = lin;
      wr_char = tab_char;
    end else begin
      wr_en = 1'b0;
    end
  end

  assign rd_addr = ctl.copy ? ptr : item_addr;

  always_ff @(posedge clk) begin
    if (wr_en) chars[wr_addr] <= wr_char;
    if (wr_color_en) colors[wr_addr] <= wr_color;
    rd_char  <= chars[rd_addr];
    rd_color <= colors[rd_addr];
  end

  // Cursor, tab and sweep state
  always_ff @(posedge clk) begin
    if (rst) begin
      default_color <= RESET_COLOR;
      row           <= '0;
      col           <= '0;
      lin           <= '0;
      phase         <= '0;
      tab_left      <= '0;
      scroll_req    <= 1'b0;
      ptr           <= '0;
      cp_pend       <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) default_color <= cfg_wdata;
      cp_pend <= ctl.copy;

      if (ctl.load) begin
        tab_left <= '0;
        if (in_func != FUNC_READ) begin
          unique case (in_char)
            CH_LF: begin
              col   <= '0;
              phase <= '0;
              if (row == LAST_ROW) begin
                scroll_req <= 1'b1;
                lin        <= lin - AW'(col);
              end else begin
                row <= row + RW'(1);
                lin <= lin - AW'(col) + ROW_STEP;
              end
            end
            CH_CR: begin
              col   <= '0;
              phase <= '0;
              lin   <= lin - AW'(col);
            end
            CH_TAB: begin
              tab_left <= TAB_N - phase;
            end
            default: begin
              tab_left <= TW'(1);
            end
          endcase
        end
      end else if (ctl.store) begin
        tab_left <= tab_left - TW'(1);
        if (col == LAST_COL) begin
          col   <= '0;
          phase <= '0;
          if (row == LAST_ROW) begin
            scroll_req <= 1'b1;
            lin        <= LAST_BASE;
          end else begin
            row <= row + RW'(1);
            lin <= lin + AW'(1);
          end
        end else begin
          col   <= col + CW'(1);
          lin   <= lin + AW'(1);
          phase <= (phase == TAB_LAST) ? '0 : phase + TW'(1);
        end
      end

      if (ctl.scroll_start) begin
        scroll_req <= 1'b0;
        ptr        <= ROW_STEP;
      end else if (ctl.drain) begin
        ptr <= LAST_BASE;
      end else if (ctl.copy || ctl.bottom || ctl.wipe) begin
        ptr <= ptr + AW'(1);
      end

      if (ctl.out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Transaction payload and response register
  always_ff @(posedge clk) begin
    cp_addr <= ptr - ROW_STEP;
    if (ctl.load) begin
      item_read <= (in_func == FUNC_READ);
      item_ok   <= (int'(in_row) < ROWS) && (int'(in_col) < COLS);
      item_addr <= AW'(int'(in_row) * COLS + int'(in_col));
      tab_char  <= (in_char == CH_TAB) ? CH_SPACE : in_char;
    end
    if (ctl.out_load) begin
      rsp.cursor_row    <= ROW_W'(row);
      rsp.cursor_col    <= COL_W'(col);
      rsp.cursor_linear <= LIN_W'(lin);
      rsp.cell_char     <= (item_read && item_ok) ? rd_char : CH_BLANK;
      rsp.cell_color    <= (item_read && item_ok) ? rd_color : '0;
    end
  end

  assign rsp.valid     = out_valid;

  assign st.item_read  = item_read;
  assign st.scroll_req = scroll_req;
  assign st.tab_zero   = (tab_left == '0);
  assign st.ptr_last   = (ptr == LAST_CELL);
  assign st.out_free   = !out_valid || rsp.ready;

endmodule

@@ hw/rtl/text_console_writer.sv @@
// ============================================================================
// Text console writer
// Character-cell console: prints bytes at a cursor and reads back cells.
// ============================================================================
// Usage:
//   cmd carries one transaction: func 0 prints char_code at the cursor,
//   func 1 reads the cell at read_row/read_col. rsp returns one transaction
//   per command with the cursor row, column and linear position, plus the
//   cell character and attribute on a read inside the screen (zero otherwise).
//   cfg_we/cfg_wdata load the attribute used for rows cleared by a scroll.
//   One command is handled at a time. rsp.valid rises in the same cycle as
//   cmd.ready returns. A read first fetches the addressed cell; a printable
//   byte is stored at the cursor; a tab stores one space for each column up
//   to the next tab stop. Each space, wrap or newline that passes the bottom
//   row scrolls: a one-cell-per-cycle copy over the single store write port.
//   After rst the store is swept to blank cells before cmd.ready rises. The
//   response sits in an output register; while the receiver stalls, the
//   next command can be taken and worked on, and only its response load
//   waits for the register to drain.
// ============================================================================
`include "text_console_writer_assert.svh"

module text_console_writer import tcw_pkg::*; #(
  parameter int COLS      = DEF_COLS,
  parameter int ROWS      = DEF_ROWS,
  parameter int TAB_WIDTH = DEF_TAB_WIDTH
) (
  input  logic               clk,
  input  logic               rst,
  tcw_cmd_if.sink            cmd,
  tcw_rsp_if.source          rsp,
  input  logic               cfg_we,
  input  logic [COLOR_W-1:0] cfg_wdata
);

  tcw_ctl_t  ctl;
  tcw_stat_t st;
  logic      in_ready;

  assign cmd.ready = in_ready;

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.valid),
    .in_ready (in_ready),
    .st       (st),
    .ctl      (ctl)
  );

  tcw_datapath #(
    .COLS      (COLS),
    .ROWS      (ROWS),
    .TAB_WIDTH (TAB_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .st        (st),
    .in_func   (cmd.func),
    .in_char   (cmd.char_code),
    .in_row    (cmd.read_row),
    .in_col    (cmd.read_col),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .rsp       (rsp)
  );

  `TCW_ASSERT_CLK(a_one_at_a_time, cmd.valid && cmd.ready |=> !cmd.ready, "command taken while busy")
  `TCW_ASSERT_NEVER(a_ctl_exclusive, !$onehot0(ctl), "controller issued overlapping commands")
  `TCW_ASSERT_CLK(a_cursor_range, rsp.valid |-> (int'(rsp.cursor_row) < ROWS) && (int'(rsp.cursor_col) < COLS), "cursor off screen")

endmodule
